FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/ncp_pkg.sv
package ncp_pkg;

   localparam int InW       = 16;
   localparam int MagW      = 32;
   localparam int SqW       = 64;
   localparam int RootW     = 32;
   localparam int OneShift  = 14;
   localparam int QW        = OneShift + 1;
   localparam int RemW      = MagW + OneShift + 1;
   localparam int SqrtCells = RootW;
   localparam int DivCells  = QW;
   localparam int SqrtIdxW  = $clog2(SqrtCells);
   localparam int DivIdxW   = $clog2(DivCells);
   localparam int OutW      = QW + 1;

   typedef struct packed {
      logic [MagW-1:0] mx;
      logic [MagW-1:0] my;
      logic [MagW-1:0] mz;
      logic            negx;
      logic            negz;
      logic            degen;
   } ncp_tag_type;

   typedef struct packed {
      logic [SqW-1:0] rem;
      logic [SqW-1:0] res;
      ncp_tag_type    tag;
   } ncp_sqrt_type;

   typedef struct packed {
      logic [RootW-1:0] d;
      logic [RemW-1:0]  rx;
      logic [RemW-1:0]  ry;
      logic [RemW-1:0]  rz;
      logic [QW-1:0]    qx;
      logic [QW-1:0]    qy;
      logic [QW-1:0]    qz;
      logic             negx;
      logic             negz;
      logic             degen;
   } ncp_div_type;

endpackage

FILE: rtl/core/ncp_req_if.sv
interface ncp_req_if import ncp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [InW-1:0] ax;
   logic signed [InW-1:0] ay;
   logic signed [InW-1:0] az;
   logic signed [InW-1:0] bx;
   logic signed [InW-1:0] by;
   logic signed [InW-1:0] bz;

   modport source (output valid, ax, ay, az, bx, by, bz, input ready);
   modport sink (input valid, ax, ay, az, bx, by, bz, output ready);
endinterface

FILE: rtl/core/ncp_rsp_if.sv
interface ncp_rsp_if import ncp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [OutW-1:0] nx;
   logic        [QW-1:0]   ny;
   logic signed [OutW-1:0] nz;
   logic                   degenerate;

   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface

FILE: rtl/core/ncp_sqrt_cell.sv
module ncp_sqrt_cell import ncp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [SqrtIdxW-1:0] idx,
   input  logic                valid_i,
   input  ncp_sqrt_type        data_i,
   output logic                valid_o,
   output ncp_sqrt_type        data_o
);

   logic [SqW-1:0] step_w;
   logic [SqW-1:0] trial;
   logic           take;
   logic           valid_ff;
   ncp_sqrt_type   data_ff, data_in;

   // This cell decides one bit of the root, taking bits from the top down.
   assign step_w = SqW'(1) << (6'(SqW - 2) - {idx, 1'b0});
   assign trial  = data_i.res + step_w;
   assign take   = data_i.rem >= trial;

   always_comb begin
      data_in     = data_i;
      data_in.rem = take ? data_i.rem - trial : data_i.rem;
      data_in.res = take ? (data_i.res >> 1) + step_w : data_i.res >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

FILE: rtl/core/ncp_div_cell.sv
module ncp_div_cell import ncp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [DivIdxW-1:0] idx,
   input  logic               valid_i,
   input  ncp_div_type        data_i,
   output logic               valid_o,
   output ncp_div_type        data_o
);

   logic [RemW-1:0] dsh;
   logic            gx, gy, gz;
   logic            valid_ff;
   ncp_div_type     data_ff, data_in;

   // Each cell settles one quotient bit for all three lanes.
   assign dsh = RemW'(data_i.d) << idx;
   assign gx  = data_i.rx >= dsh;
   assign gy  = data_i.ry >= dsh;
   assign gz  = data_i.rz >= dsh;

   always_comb begin
      data_in    = data_i;
      data_in.rx = gx ? data_i.rx - dsh : data_i.rx;
      data_in.ry = gy ? data_i.ry - dsh : data_i.ry;
      data_in.rz = gz ? data_i.rz - dsh : data_i.rz;
      data_in.qx = data_i.qx | (QW'(gx) << idx);
      data_in.qy = data_i.qy | (QW'(gy) << idx);
      data_in.qz = data_i.qz | (QW'(gz) << idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

FILE: rtl/core/normalized_cross_product.sv
// Unit normal of two Q8.8 vectors: the cross product is scaled by its
// integer-square-root length to Q1.14, rounded to nearest, and folded so
// that ny is never negative; a zero cross product gives zeros and sets
// degenerate. The block takes one item every cycle while ready is high and
// returns results in order through stages for products, differences, squares
// and sum, a chain of 32 square-root cells (one root bit each), a register of
// numerator set-up, 15 division cells (one quotient bit each) and the output
// register. A skid register behind the output lets the pipeline keep
// accepting while one result waits; ready falls only once both are full.
`include "assert_macros.svh"

module normalized_cross_product import ncp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ncp_req_if.sink   req_chan,
   ncp_rsp_if.source rsp_chan
);

   localparam int ProdW = 2 * InW;

   logic en;

   // Products.
   logic                    v1_ff;
   logic signed [ProdW-1:0] p_ff [6];

   // Differences and magnitudes.
   logic                  v2_ff;
   ncp_tag_type           t2_ff, t2_in;
   logic signed [ProdW:0] cx, cy, cz;

   // Squares.
   logic           v3_ff;
   ncp_tag_type    t3_ff;
   logic [SqW-1:0] sx_ff, sy_ff, sz_ff;

   // Sum.
   logic           v4_ff;
   ncp_sqrt_type   s4_ff;

   logic           sqrt_v [SqrtCells+1];
   ncp_sqrt_type   sqrt_d [SqrtCells+1];

   logic           v5_ff;
   ncp_div_type    d5_ff, d5_in;
   ncp_tag_type    t5;

   logic           div_v [DivCells+1];
   ncp_div_type    div_d [DivCells+1];

   logic           push, take_out;
   ncp_div_type    last;
   logic signed [OutW-1:0] nx_w, nz_w;
   logic [QW-1:0]  ny_w;
   logic           out_valid_ff, skid_valid_ff;
   logic signed [OutW-1:0] onx_ff, onz_ff, snx_ff, snz_ff;
   logic [QW-1:0]  ony_ff, sny_ff;
   logic           odg_ff, sdg_ff;
   logic           out_zero;

   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= sqrt_v[SqrtCells];
      end
   end

   assign cx = {p_ff[0][ProdW-1], p_ff[0]} - {p_ff[1][ProdW-1], p_ff[1]};
   assign cy = {p_ff[2][ProdW-1], p_ff[2]} - {p_ff[3][ProdW-1], p_ff[3]};
   assign cz = {p_ff[4][ProdW-1], p_ff[4]} - {p_ff[5][ProdW-1], p_ff[5]};

   always_comb begin
      t2_in.mx    = MagW'(cx[ProdW] ? -cx : cx);
      t2_in.my    = MagW'(cy[ProdW] ? -cy : cy);
      t2_in.mz    = MagW'(cz[ProdW] ? -cz : cz);
      // A negative y flips every sign, so y itself never ends negative.
      t2_in.negx  = cx[ProdW] ^ cy[ProdW];
      t2_in.negz  = cz[ProdW] ^ cy[ProdW];
      t2_in.degen = (cx == '0) && (cy == '0) && (cz == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= req_chan.ay * req_chan.bz;
         p_ff[1] <= req_chan.az * req_chan.by;
         p_ff[2] <= req_chan.az * req_chan.bx;
         p_ff[3] <= req_chan.ax * req_chan.bz;
         p_ff[4] <= req_chan.ax * req_chan.by;
         p_ff[5] <= req_chan.ay * req_chan.bx;
         t2_ff   <= t2_in;
         sx_ff   <= SqW'(t2_ff.mx) * SqW'(t2_ff.mx);
         sy_ff   <= SqW'(t2_ff.my) * SqW'(t2_ff.my);
         sz_ff   <= SqW'(t2_ff.mz) * SqW'(t2_ff.mz);
         t3_ff   <= t2_ff;
         s4_ff.rem <= sx_ff + sy_ff + sz_ff;
         s4_ff.res <= '0;
         s4_ff.tag <= t3_ff;
         d5_ff   <= d5_in;
      end
   end

   assign sqrt_v[0] = v4_ff;
   assign sqrt_d[0] = s4_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      ncp_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .idx     (SqrtIdxW'(i)),
         .valid_i (sqrt_v[i]),
         .data_i  (sqrt_d[i]),
         .valid_o (sqrt_v[i+1]),
         .data_o  (sqrt_d[i+1])
      );
   end

   // Numerators carry half the divisor so the quotient rounds to nearest.
   always_comb begin
      t5          = sqrt_d[SqrtCells].tag;
      d5_in.d     = sqrt_d[SqrtCells].res[RootW-1:0];
      d5_in.rx    = (RemW'(t5.mx) << OneShift) + RemW'(d5_in.d[RootW-1:1]);
      d5_in.ry    = (RemW'(t5.my) << OneShift) + RemW'(d5_in.d[RootW-1:1]);
      d5_in.rz    = (RemW'(t5.mz) << OneShift) + RemW'(d5_in.d[RootW-1:1]);
      d5_in.qx    = '0;
      d5_in.qy    = '0;
      d5_in.qz    = '0;
      d5_in.negx  = t5.negx;
      d5_in.negz  = t5.negz;
      d5_in.degen = t5.degen;
   end

   assign div_v[0] = v5_ff;
   assign div_d[0] = d5_ff;

   for (genvar i = 0; i < DivCells; i++) begin : g_div
      ncp_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .idx     (DivIdxW'(DivCells - 1 - i)),
         .valid_i (div_v[i]),
         .data_i  (div_d[i]),
         .valid_o (div_v[i+1]),
         .data_o  (div_d[i+1])
      );
   end

   assign last = div_d[DivCells];
   assign push = en && div_v[DivCells];
   assign take_out = out_valid_ff && rsp_chan.ready;

   always_comb begin
      nx_w = '0;
      ny_w = '0;
      nz_w = '0;
      if (!last.degen) begin
         nx_w = last.negx ? -OutW'(last.qx) : OutW'(last.qx);
         ny_w = last.qy;
         nz_w = last.negz ? -OutW'(last.qz) : OutW'(last.qz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take_out) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            onx_ff <= snx_ff;
            ony_ff <= sny_ff;
            onz_ff <= snz_ff;
            odg_ff <= sdg_ff;
         end else begin
            onx_ff <= nx_w;
            ony_ff <= ny_w;
            onz_ff <= nz_w;
            odg_ff <= last.degen;
         end
      end else if (push) begin
         snx_ff <= nx_w;
         sny_ff <= ny_w;
         snz_ff <= nz_w;
         sdg_ff <= last.degen;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.nx         = onx_ff;
   assign rsp_chan.ny         = ony_ff;
   assign rsp_chan.nz         = onz_ff;
   assign rsp_chan.degenerate = odg_ff;

   assign out_zero = (onx_ff == '0) && (ony_ff == '0) && (onz_ff == '0);

   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_IMPLIES(a_degen_zero, clock, reset, rsp_chan.valid && rsp_chan.degenerate, out_zero)
   `ASSERT_IMPLIES(a_ny_range, clock, reset, rsp_chan.valid, rsp_chan.ny <= QW'(1 << OneShift))
   `ASSERT_NEXT(a_skid_fills, clock, reset, out_valid_ff && !rsp_chan.ready && push, skid_valid_ff)

endmodule

FILE: bench/ncp_bench_pkg.sv
package ncp_bench_pkg;
   import ncp_pkg::*;

   typedef struct packed {
      logic signed [InW-1:0] ax;
      logic signed [InW-1:0] ay;
      logic signed [InW-1:0] az;
      logic signed [InW-1:0] bx;
      logic signed [InW-1:0] by;
      logic signed [InW-1:0] bz;
   } vec_pair_type;

   typedef struct packed {
      logic signed [OutW-1:0] nx;
      logic        [QW-1:0]   ny;
      logic signed [OutW-1:0] nz;
      logic                   degenerate;
   } unit_normal_type;

endpackage

FILE: bench/ncp_checker.sv
module ncp_checker import ncp_pkg::*; import ncp_bench_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ncp_req_if        req_chan,
   ncp_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_normals
);

   unit_normal_type expected_normals[$];

   // Integer square root, rounded down, one result bit per pass.
   function automatic longint unsigned floor_root(longint unsigned s);
      longint unsigned root;
      longint unsigned bitval;
      root   = 0;
      bitval = 64'd1 << 62;
      while (bitval > s) bitval >>= 2;
      while (bitval != 0) begin
         if (s >= root + bitval) begin
            s    = s - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root >>= 1;
         end
         bitval >>= 2;
      end
      return root;
   endfunction

   function automatic logic [OutW-1:0] scale_component(longint signed c,
                                                       longint unsigned len,
                                                       logic flip);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-c) : longint'(c);
      q   = ((mag << OneShift) + (len >> 1)) / len;
      if ((c < 0) != flip) q = -q;
      return q[OutW-1:0];
   endfunction

   function automatic unit_normal_type unit_normal_of(vec_pair_type v);
      longint signed   cx, cy, cz;
      longint unsigned sq, len;
      logic            flip;
      logic [OutW-1:0] yfull;
      unit_normal_type n;
      cx = longint'(v.ay) * v.bz - longint'(v.az) * v.by;
      cy = longint'(v.az) * v.bx - longint'(v.ax) * v.bz;
      cz = longint'(v.ax) * v.by - longint'(v.ay) * v.bx;
      sq = cx * cx + cy * cy + cz * cz;
      n  = '0;
      if (sq == 0) begin
         n.degenerate = 1'b1;
         return n;
      end
      len   = floor_root(sq);
      flip  = cy < 0;
      n.nx  = scale_component(cx, len, flip);
      yfull = scale_component(cy, len, flip);
      n.ny  = yfull[QW-1:0];
      n.nz  = scale_component(cz, len, flip);
      return n;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("error at %0t: %s got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   assign pending_normals = expected_normals.size();

   always @(posedge clock) begin
      vec_pair_type    v;
      unit_normal_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            v = '{req_chan.ax, req_chan.ay, req_chan.az,
                  req_chan.bx, req_chan.by, req_chan.bz};
            expected_normals.push_back(unit_normal_of(v));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_normals.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               want = expected_normals.pop_front();
               if (rsp_chan.nx !== want.nx)
                  report_mismatch("nx", rsp_chan.nx, want.nx);
               if (rsp_chan.ny !== want.ny)
                  report_mismatch("ny", rsp_chan.ny, want.ny);
               if (rsp_chan.nz !== want.nz)
                  report_mismatch("nz", rsp_chan.nz, want.nz);
               if (rsp_chan.degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_chan.degenerate, want.degenerate);
            end
         end
      end
   end

endmodule

FILE: bench/testbench.sv
module testbench import ncp_pkg::*; import ncp_bench_pkg::*;;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_normals;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_off_cycles = 0;

   ncp_req_if req_chan ();
   ncp_rsp_if rsp_chan ();

   normalized_cross_product dut (.clock, .reset, .req_chan, .rsp_chan);
   ncp_checker checker_inst (.clock, .reset, .req_chan, .rsp_chan,
                             .fail_count, .pending_normals);

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      {req_chan.ax, req_chan.ay, req_chan.az} = '0;
      {req_chan.bx, req_chan.by, req_chan.bz} = '0;
      rsp_chan.ready = 0;
   end

   // Receiver: a long hold-off, when asked for, overrides the random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready  <= 0;
      end else begin
         rsp_chan.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("normalized_cross_product: mismatch");
         $finish;
      end
   end

   task automatic send_pair(vec_pair_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      {req_chan.ax, req_chan.ay, req_chan.az} <= {v.ax, v.ay, v.az};
      {req_chan.bx, req_chan.by, req_chan.bz} <= {v.bx, v.by, v.bz};
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_normals != 0) @(posedge clock);
   endtask

   function automatic logic signed [InW-1:0] pick_component();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return InW'($urandom_range(7) - 4);
         default: return InW'($urandom);
      endcase
   endfunction

   function automatic vec_pair_type random_pair();
      vec_pair_type v;
      v = {pick_component(), pick_component(), pick_component(),
           pick_component(), pick_component(), pick_component()};
      // Some pairs are parallel, or have a zero vector, to reach the degenerate case.
      case ($urandom_range(9))
         0: {v.bx, v.by, v.bz} = {v.ax, v.ay, v.az};
         1: {v.bx, v.by, v.bz} = {-v.ax, -v.ay, -v.az};
         2: {v.ax, v.ay, v.az} = '0;
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      vec_pair_type directed[$];
      int           idle_modes[4];
      int           stall_modes[4];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed = '{
         '{16'sh0100, 0, 0, 0, 16'sh0100, 0},
         '{0, 16'sh0100, 0, 16'sh0100, 0, 0},
         '{16'sh0100, 0, 0, 0, 0, 16'sh0100},
         '{0, 0, 0, 16'sh1234, 16'sh0022, -16'sh0100},
         '{16'sh0200, 16'sh0300, 16'sh0400, 16'sh0200, 16'sh0300, 16'sh0400},
         '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000},
         '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000},
         '{16'sh8000, 0, 0, 0, 0, 16'sh8000},
         '{16'sh8000, 0, 0, 0, 16'sh8000, 0},
         '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0},
         '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000},
         '{1, 0, 0, 0, 0, 1},
         '{1, 1, 0, 0, 1, 1},
         '{1, 2, 3, 4, 5, 6},
         '{-1, -1, -1, 1, 0, 0},
         '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}
      };
      foreach (directed[i]) send_pair(directed[i]);
      drain();

      // Fill the pipeline and skid while the receiver holds off.
      hold_off_cycles <= 150;
      repeat (90) send_pair(random_pair());
      drain();

      idle_modes  = '{0, 86, 0, 19};
      stall_modes = '{0, 0, 86, 19};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_modes[phase];
         recv_stall_pct = stall_modes[phase];
         repeat (75) send_pair(random_pair());
         drain();
      end

      recv_stall_pct = 0;
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("normalized_cross_product: match");
      end else begin
         $display("normalized_cross_product: mismatch");
      end
      $finish;
   end

endmodule
